>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk_i and off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset
`define GSCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds out of reset
`define GSCT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/gsct_pkg.sv
// ----------------------------------------------------------------------------
// gsct_pkg
// Widths, constants, saturating helpers and cell types of the growing
// sphere collision time predictor.
// ----------------------------------------------------------------------------
package gsct_pkg;

  localparam int WordW  = 48;
  localparam int FracW  = 32;
  localparam int TimeW  = WordW - 1;
  localparam int HalfW  = WordW / 2;
  localparam int ProdW  = 2 * WordW;
  // root of a positive word shifted up by the fraction
  localparam int RootW  = (WordW - 1 + FracW + 1) / 2;
  localparam int RadW   = 2 * RootW;
  localparam int RemW   = RootW + 2;
  // quotient bits below the saturation point
  localparam int QuoW   = WordW - 1;
  localparam int DivSh  = QuoW - FracW;
  localparam int MulLat = 2;

  typedef logic signed [WordW-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordW-1){1'b0}}};
  localparam word_t One     = word_t'({1'b1, {FracW{1'b0}}});
  localparam word_t Two     = word_t'({2'b10, {FracW{1'b0}}});
  localparam logic signed [WordW:0] WideMax = {2'b00, {(WordW-1){1'b1}}};
  localparam logic signed [WordW:0] WideMin = {2'b11, {(WordW-1){1'b0}}};
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // One step of the integer square root
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sqrt_t;

  // One step of the restoring divider
  typedef struct packed {
    logic [WordW-1:0] rem;
    logic [QuoW-1:0]  quo;
    logic [QuoW-1:0]  nlo;
    logic [WordW-1:0] dm;
  } div_t;

  function automatic word_t sat(input logic signed [WordW:0] v);
    word_t r;
    if (v > WideMax) begin
      r = WordMax;
    end else if (v < WideMin) begin
      r = WordMin;
    end else begin
      r = v[WordW-1:0];
    end
    return r;
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    return sat(s);
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} - {b[WordW-1], b};
    return sat(s);
  endfunction

  function automatic logic [WordW-1:0] mag(input word_t a);
    logic [WordW-1:0] u;
    u = a;
    return a[WordW-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

>>> rtl/gsct_mul.sv
// ----------------------------------------------------------------------------
// gsct_mul
// Two-stage saturating fixed-point multiplier: half-word partial products,
// then sum, round to nearest (ties away from zero) and saturate.
// ----------------------------------------------------------------------------
module gsct_mul (
  input  logic             clk_i,
  input  logic             en_i,
  input  gsct_pkg::word_t  a_i,
  input  gsct_pkg::word_t  b_i,
  output gsct_pkg::word_t  p_o
);

  localparam int PartW = 2 * gsct_pkg::HalfW;

  logic [gsct_pkg::WordW-1:0] ma, mb;
  logic             neg_q;
  logic [PartW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [gsct_pkg::ProdW-1:0] sum, res, lim, m;
  gsct_pkg::word_t  p_q;

  assign ma = gsct_pkg::mag(a_i);
  assign mb = gsct_pkg::mag(b_i);

  // Form partial products of the magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= a_i[gsct_pkg::WordW-1] ^ b_i[gsct_pkg::WordW-1];
      p00_q <= PartW'(ma[gsct_pkg::HalfW-1:0]) * PartW'(mb[gsct_pkg::HalfW-1:0]);
      p01_q <= PartW'(ma[gsct_pkg::HalfW-1:0]) * PartW'(mb[gsct_pkg::WordW-1:gsct_pkg::HalfW]);
      p10_q <= PartW'(ma[gsct_pkg::WordW-1:gsct_pkg::HalfW]) * PartW'(mb[gsct_pkg::HalfW-1:0]);
      p11_q <= PartW'(ma[gsct_pkg::WordW-1:gsct_pkg::HalfW])
             * PartW'(mb[gsct_pkg::WordW-1:gsct_pkg::HalfW]);
    end
  end

  // Sum, round and clamp to the signed word range
  always_comb begin
    sum = gsct_pkg::ProdW'(p00_q)
        + ((gsct_pkg::ProdW'(p01_q) + gsct_pkg::ProdW'(p10_q)) << gsct_pkg::HalfW)
        + (gsct_pkg::ProdW'(p11_q) << PartW)
        + (gsct_pkg::ProdW'(1) << (gsct_pkg::FracW - 1));
    res = sum >> gsct_pkg::FracW;
    lim = neg_q ? gsct_pkg::ProdW'(gsct_pkg::WordMax) + 1'b1
                : gsct_pkg::ProdW'(gsct_pkg::WordMax);
    m   = (res > lim) ? lim : res;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg_q ? gsct_pkg::WordW'(~m + 1'b1) : gsct_pkg::WordW'(m);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/gsct_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gsct_sqrt_cell
// One root bit of a digit-by-digit integer square root; hands remainder,
// partial root and remaining radicand to the next cell.
// ----------------------------------------------------------------------------
module gsct_sqrt_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  gsct_pkg::sqrt_t   cell_i,
  output gsct_pkg::sqrt_t   cell_o
);

  logic [gsct_pkg::RemW+1:0] rem_sh, trial;
  logic                      ge;
  gsct_pkg::sqrt_t           cell_d, cell_q;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {cell_i.rem, cell_i.rad[gsct_pkg::RadW-1 -: 2]};
    trial  = (gsct_pkg::RemW + 2)'({cell_i.root, 2'b01});
    ge     = (rem_sh >= trial);
    cell_d.rem  = ge ? gsct_pkg::RemW'(rem_sh - trial) : gsct_pkg::RemW'(rem_sh);
    cell_d.root = {cell_i.root[gsct_pkg::RootW-2:0], ge};
    cell_d.rad  = cell_i.rad << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/gsct_div_cell.sv
// ----------------------------------------------------------------------------
// gsct_div_cell
// One quotient bit of a restoring divider; hands remainder, quotient,
// remaining dividend bits and divisor to the next cell.
// ----------------------------------------------------------------------------
module gsct_div_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  gsct_pkg::div_t   cell_i,
  output gsct_pkg::div_t   cell_o
);

  logic [gsct_pkg::WordW:0] rem_sh, dm_x;
  logic                     ge;
  gsct_pkg::div_t           cell_d, cell_q;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    rem_sh = {cell_i.rem, cell_i.nlo[gsct_pkg::QuoW-1]};
    dm_x   = {1'b0, cell_i.dm};
    ge     = (rem_sh >= dm_x);
    cell_d.rem = ge ? gsct_pkg::WordW'(rem_sh - dm_x) : gsct_pkg::WordW'(rem_sh);
    cell_d.quo = {cell_i.quo[gsct_pkg::QuoW-2:0], ge};
    cell_d.nlo = cell_i.nlo << 1;
    cell_d.dm  = cell_i.dm;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/growing_sphere_collision_time.sv
// Throughput: one item per cycle while the output queue has room, through 8 multiplier stages, 40 root cells,
// one divider setup stage and 47 divider cells.
// A two-entry output queue lets new items in while one result waits.
// Reset clears stage valid flags, the output queue and growth_rate to zero.
// ----------------------------------------------------------------------------
// growing_sphere_collision_time
// Approach and separation times of a sphere pair with linearly growing
// diameters, in signed saturating fixed point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module growing_sphere_collision_time (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gsct_pkg::WordW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [gsct_pkg::WordW-1:0] rv_dot_i,
  input  logic [gsct_pkg::TimeW-1:0]     vel_sq_i,
  input  logic [gsct_pkg::TimeW-1:0]     dist_sq_i,
  input  logic [gsct_pkg::TimeW-1:0]     diameter_sq_i,
  input  logic [gsct_pkg::TimeW-1:0]     sys_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           in_found_o,
  output logic [gsct_pkg::TimeW-1:0]     in_time_o,
  output logic                           out_found_o,
  output logic [gsct_pkg::TimeW-1:0]     out_time_o,
  output logic                           overlapping_o
);

  localparam int Depth = 4 * gsct_pkg::MulLat + gsct_pkg::RootW + 1 + gsct_pkg::QuoW;

  typedef struct packed {
    gsct_pkg::word_t rv, v2, r2, d2, t, g;
  } side1_t;
  typedef struct packed {
    gsct_pkg::word_t rv, v2, r2, d2, g;
  } side2_t;
  typedef struct packed {
    gsct_pkg::word_t rv, r2, a;
  } side3_t;
  typedef struct packed {
    gsct_pkg::word_t a, b, cin, cout;
  } side4_t;
  typedef struct packed {
    gsct_pkg::word_t a, b, cin, cout;
    logic in_f, out_f, ovl;
  } side5_t;
  typedef struct packed {
    logic [1:0] neg, ovf;
    logic in_f, out_f, ovl;
  } side6_t;
  typedef struct packed {
    logic                       in_found;
    logic [gsct_pkg::TimeW-1:0] in_time;
    logic                       out_found;
    logic [gsct_pkg::TimeW-1:0] out_time;
    logic                       ovl;
  } res_t;

  gsct_pkg::word_t growth_q;
  logic            en, in_acc, push, pop;
  logic [Depth-1:0] vld_q;

  // Hold the growth rate register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      growth_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      growth_q <= cfg_data_i;
    end
  end

  // Advance the whole pipeline while the output queue has room
  logic [1:0] cnt_q;
  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_acc};
    end
  end

  // Level 1: g*g and g*t
  side1_t          s1_d, s1a_q, s1b_q;
  gsct_pkg::word_t p_gg, p_gt;

  always_comb begin
    s1_d.rv = rv_dot_i;
    s1_d.v2 = gsct_pkg::word_t'({1'b0, vel_sq_i});
    s1_d.r2 = gsct_pkg::word_t'({1'b0, dist_sq_i});
    s1_d.d2 = gsct_pkg::word_t'({1'b0, diameter_sq_i});
    s1_d.t  = gsct_pkg::word_t'({1'b0, sys_time_i});
    s1_d.g  = growth_q;
  end

  gsct_mul u_mul_gg (.clk_i, .en_i(en), .a_i(s1_d.g), .b_i(s1_d.g), .p_o(p_gg));
  gsct_mul u_mul_gt (.clk_i, .en_i(en), .a_i(s1_d.g), .b_i(s1_d.t), .p_o(p_gt));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1a_q <= s1_d;
      s1b_q <= s1a_q;
    end
  end

  // Level 2: gt*(2+gt), g2*t, g2*d2
  side2_t          s2_d, s2a_q, s2b_q;
  gsct_pkg::word_t p_sp, p_g2t, p_g2d, two_gt;

  always_comb begin
    two_gt  = gsct_pkg::sadd(gsct_pkg::Two, p_gt);
    s2_d.rv = s1b_q.rv;
    s2_d.v2 = s1b_q.v2;
    s2_d.r2 = s1b_q.r2;
    s2_d.d2 = s1b_q.d2;
    s2_d.g  = s1b_q.g;
  end

  gsct_mul u_mul_sp  (.clk_i, .en_i(en), .a_i(p_gt), .b_i(two_gt),   .p_o(p_sp));
  gsct_mul u_mul_g2t (.clk_i, .en_i(en), .a_i(p_gg), .b_i(s1b_q.t),  .p_o(p_g2t));
  gsct_mul u_mul_g2d (.clk_i, .en_i(en), .a_i(p_gg), .b_i(s1b_q.d2), .p_o(p_g2d));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2a_q <= s2_d;
      s2b_q <= s2a_q;
    end
  end

  // Level 3: d2*s and d2*(g2*t + g); a = v2 - g2*d2
  side3_t          s3_d, s3a_q, s3b_q;
  gsct_pkg::word_t s_fac, m_fac, p_ds, p_m;

  always_comb begin
    s_fac   = gsct_pkg::sadd(gsct_pkg::One, p_sp);
    m_fac   = gsct_pkg::sadd(p_g2t, s2b_q.g);
    s3_d.rv = s2b_q.rv;
    s3_d.r2 = s2b_q.r2;
    s3_d.a  = gsct_pkg::ssub(s2b_q.v2, p_g2d);
  end

  gsct_mul u_mul_ds (.clk_i, .en_i(en), .a_i(s2b_q.d2), .b_i(s_fac), .p_o(p_ds));
  gsct_mul u_mul_m  (.clk_i, .en_i(en), .a_i(s2b_q.d2), .b_i(m_fac), .p_o(p_m));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3a_q <= s3_d;
      s3b_q <= s3a_q;
    end
  end

  // Level 4: b*b, a*cin, a*cout
  side4_t          s4_d, s4a_q, s4b_q;
  gsct_pkg::word_t p_bb, p_acin, p_acout;

  always_comb begin
    s4_d.a    = s3b_q.a;
    s4_d.b    = gsct_pkg::ssub(s3b_q.rv, p_m);
    s4_d.cin  = gsct_pkg::ssub(s3b_q.r2, p_ds);
    s4_d.cout = gsct_pkg::ssub(p_ds, s3b_q.r2);
  end

  gsct_mul u_mul_bb    (.clk_i, .en_i(en), .a_i(s4_d.b), .b_i(s4_d.b),    .p_o(p_bb));
  gsct_mul u_mul_acin  (.clk_i, .en_i(en), .a_i(s4_d.a), .b_i(s4_d.cin),  .p_o(p_acin));
  gsct_mul u_mul_acout (.clk_i, .en_i(en), .a_i(s4_d.a), .b_i(s4_d.cout), .p_o(p_acout));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4a_q <= s4_d;
      s4b_q <= s4a_q;
    end
  end

  // Level 5: discriminants, root conditions, then the root cells
  side5_t          s5_d;
  side5_t          s5_q [gsct_pkg::RootW];
  gsct_pkg::word_t arg_in, arg_out;
  gsct_pkg::sqrt_t sq_in [2];
  gsct_pkg::sqrt_t sq_c [2][gsct_pkg::RootW+1];

  always_comb begin
    arg_in     = gsct_pkg::ssub(p_bb, p_acin);
    arg_out    = gsct_pkg::sadd(p_bb, p_acout);
    s5_d.a     = s4b_q.a;
    s5_d.b     = s4b_q.b;
    s5_d.cin   = s4b_q.cin;
    s5_d.cout  = s4b_q.cout;
    s5_d.in_f  = s4b_q.b[gsct_pkg::WordW-1] && (arg_in > 0);
    s5_d.out_f = (arg_out > 0) && (s4b_q.a > 0);
    s5_d.ovl   = s4b_q.cin[gsct_pkg::WordW-1];
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
    sq_in[0].rad  = (arg_in > 0)
                  ? (gsct_pkg::RadW'(arg_in[gsct_pkg::WordW-2:0]) << gsct_pkg::FracW) : '0;
    sq_in[1].rem  = '0;
    sq_in[1].root = '0;
    sq_in[1].rad  = (arg_out > 0)
                  ? (gsct_pkg::RadW'(arg_out[gsct_pkg::WordW-2:0]) << gsct_pkg::FracW) : '0;
  end

  for (genvar l = 0; l < 2; l++) begin : g_sq_lane
    assign sq_c[l][0] = sq_in[l];
    for (genvar k = 0; k < gsct_pkg::RootW; k++) begin : g_sq_cell
      gsct_sqrt_cell u_cell (
        .clk_i,
        .en_i  (en),
        .cell_i(sq_c[l][k]),
        .cell_o(sq_c[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q[0] <= s5_d;
      for (int k = 1; k < gsct_pkg::RootW; k++) begin
        s5_q[k] <= s5_q[k-1];
      end
    end
  end

  // Divider setup: numerators and denominators of both roots
  side5_t          s5_last;
  gsct_pkg::word_t rt_in, rt_out;
  gsct_pkg::word_t num_d [2];
  gsct_pkg::word_t den_d [2];
  gsct_pkg::word_t num_q [2];
  gsct_pkg::word_t den_q [2];
  logic            in_f_q, out_f_q, ovl_q;

  always_comb begin
    s5_last  = s5_q[gsct_pkg::RootW-1];
    rt_in    = gsct_pkg::word_t'({1'b0, sq_c[0][gsct_pkg::RootW].root});
    rt_out   = gsct_pkg::word_t'({1'b0, sq_c[1][gsct_pkg::RootW].root});
    num_d[0] = s5_last.cin;
    den_d[0] = gsct_pkg::ssub(rt_in, s5_last.b);
    if (s5_last.b[gsct_pkg::WordW-1]) begin
      num_d[1] = gsct_pkg::ssub(rt_out, s5_last.b);
      den_d[1] = s5_last.a;
    end else begin
      num_d[1] = s5_last.cout;
      den_d[1] = gsct_pkg::sadd(rt_out, s5_last.b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q   <= num_d;
      den_q   <= den_d;
      in_f_q  <= s5_last.in_f;
      out_f_q <= s5_last.out_f;
      ovl_q   <= s5_last.ovl;
    end
  end

  // Divider cells: magnitudes, saturation check, then one bit per cell
  localparam int CmpW = gsct_pkg::WordW + gsct_pkg::DivSh;

  side6_t                     s6_d;
  side6_t                     s6_q [gsct_pkg::QuoW];
  logic [gsct_pkg::WordW-1:0] nm [2];
  logic [gsct_pkg::WordW-1:0] dm [2];
  gsct_pkg::div_t             dv_in [2];
  gsct_pkg::div_t             dv_c [2][gsct_pkg::QuoW+1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nm[l] = gsct_pkg::mag(num_q[l]);
      dm[l] = gsct_pkg::mag(den_q[l]);
      s6_d.neg[l] = num_q[l][gsct_pkg::WordW-1] ^ den_q[l][gsct_pkg::WordW-1];
      s6_d.ovf[l] = (CmpW'(nm[l]) >= (CmpW'(dm[l]) << gsct_pkg::DivSh));
      dv_in[l].rem = nm[l] >> gsct_pkg::DivSh;
      dv_in[l].quo = '0;
      dv_in[l].nlo = {nm[l][gsct_pkg::DivSh-1:0], {gsct_pkg::FracW{1'b0}}};
      dv_in[l].dm  = dm[l];
    end
    s6_d.in_f  = in_f_q;
    s6_d.out_f = out_f_q;
    s6_d.ovl   = ovl_q;
  end

  for (genvar l = 0; l < 2; l++) begin : g_dv_lane
    assign dv_c[l][0] = dv_in[l];
    for (genvar k = 0; k < gsct_pkg::QuoW; k++) begin : g_dv_cell
      gsct_div_cell u_cell (
        .clk_i,
        .en_i  (en),
        .cell_i(dv_c[l][k]),
        .cell_o(dv_c[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q[0] <= s6_d;
      for (int k = 1; k < gsct_pkg::QuoW; k++) begin
        s6_q[k] <= s6_q[k-1];
      end
    end
  end

  // Clamp quotients into times; drop roots that were not found
  side6_t                     s6_last;
  logic [gsct_pkg::QuoW-1:0]  q_in, q_out;
  res_t                       res_d;

  always_comb begin
    s6_last = s6_q[gsct_pkg::QuoW-1];
    q_in    = dv_c[0][gsct_pkg::QuoW].quo;
    q_out   = dv_c[1][gsct_pkg::QuoW].quo;
    res_d.in_found  = s6_last.in_f;
    res_d.out_found = s6_last.out_f;
    res_d.ovl       = s6_last.ovl;
    if (!s6_last.in_f || s6_last.neg[0] || (!s6_last.ovf[0] && q_in == '0)) begin
      res_d.in_time = '0;
    end else if (s6_last.ovf[0]) begin
      res_d.in_time = gsct_pkg::TimeMax;
    end else begin
      res_d.in_time = q_in;
    end
    if (!s6_last.out_f || s6_last.neg[1] || (!s6_last.ovf[1] && q_out == '0)) begin
      res_d.out_time = '0;
    end else if (s6_last.ovf[1]) begin
      res_d.out_time = gsct_pkg::TimeMax;
    end else begin
      res_d.out_time = q_out;
    end
  end

  // Output queue: two entries part the pipeline from the consumer
  res_t fifo_q [2];
  logic wr_q, rd_q;

  assign push = en && vld_q[Depth-1];
  assign pop  = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res_d;
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign in_found_o    = fifo_q[rd_q].in_found;
  assign in_time_o     = fifo_q[rd_q].in_time;
  assign out_found_o   = fifo_q[rd_q].out_found;
  assign out_time_o    = fifo_q[rd_q].out_time;
  assign overlapping_o = fifo_q[rd_q].ovl;

  // Checks
  `GSCT_NEVER(a_cnt_range, cnt_q == 2'd3, "output queue count out of range")
  `GSCT_ASSERT(a_cnt_track, cnt_q == $past(cnt_q) + 2'($past(push)) - 2'($past(pop)), "queue count lost an item")
  `GSCT_NEVER(a_in_time_zero, out_valid_o && !in_found_o && in_time_o != '0, "approach time without root")
  `GSCT_NEVER(a_out_time_zero, out_valid_o && !out_found_o && out_time_o != '0, "separation time without root")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pair queries through growing_sphere_collision_time under several
// growth rates, with bursty input and random output stall, and checks each
// result against a fixed-point collision time predictor.
// ----------------------------------------------------------------------------

typedef struct {
  longint rv;
  longint v2;
  longint r2;
  longint d2;
  longint t;
} pair_query_t;

typedef struct {
  bit          in_found;
  bit [46:0]   in_time;
  bit          out_found;
  bit [46:0]   out_time;
  bit          overlapping;
} contact_times_t;

class contact_scoreboard;
  localparam longint WMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint WMin = -WMax - 1;

  longint         growth;
  contact_times_t expected_q[$];
  int             errors;

  function new();
    growth = 0;
    errors = 0;
  endfunction

  function longint clampw(longint a);
    if (a > WMax) return WMax;
    if (a < WMin) return WMin;
    return a;
  endfunction

  function bit [127:0] mag(longint a);
    bit [127:0] r;
    r = (a < 0) ? -a : a;
    return r;
  endfunction

  // Saturate a magnitude with sign to the word range
  function longint sat_mag(bit neg, bit [127:0] m);
    bit [127:0] lim;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  // Round half away from zero after the fraction shift
  function longint fmul(longint a, longint b);
    bit [127:0] p;
    p = mag(a) * mag(b);
    p = p + (128'd1 << 31);
    return sat_mag((a < 0) != (b < 0), p >> 32);
  endfunction

  function longint froot(longint x);
    bit [127:0] rad, r, c;
    if (x <= 0) return 0;
    rad = mag(x) << 32;
    r = 0;
    for (int i = 40; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= rad) r = c;
    end
    return sat_mag(1'b0, r);
  endfunction

  function longint fdiv(longint n, longint d);
    bit neg;
    neg = (n < 0) != (d < 0);
    if (d == 0) return sat_mag(neg, 128'd1 << 100);
    return sat_mag(neg, (mag(n) << 32) / mag(d));
  endfunction

  function bit [46:0] to_time(longint v);
    if (v <= 0) return '0;
    return v[46:0];
  endfunction

  function contact_times_t predict(pair_query_t q);
    contact_times_t res;
    longint g2, gt, s, ds, b, a, bb, cin, cout, arg_in, arg_out, rt;
    g2 = fmul(growth, growth);
    gt = fmul(growth, q.t);
    s = clampw((64'sd1 << 32) + fmul(gt, clampw((64'sd2 << 32) + gt)));
    ds = fmul(q.d2, s);
    b = clampw(q.rv - fmul(q.d2, clampw(fmul(g2, q.t) + growth)));
    a = clampw(q.v2 - fmul(g2, q.d2));
    bb = fmul(b, b);
    cin = clampw(q.r2 - ds);
    cout = clampw(ds - q.r2);
    arg_in = clampw(bb - fmul(a, cin));
    arg_out = clampw(bb + fmul(a, cout));
    res = '{default: 0};
    if (b < 0 && arg_in > 0) begin
      res.in_found = 1'b1;
      res.in_time = to_time(fdiv(cin, clampw(froot(arg_in) - b)));
    end
    if (arg_out > 0 && a > 0) begin
      rt = froot(arg_out);
      res.out_found = 1'b1;
      if (b < 0) begin
        res.out_time = to_time(fdiv(clampw(rt - b), a));
      end else begin
        res.out_time = to_time(fdiv(cout, clampw(rt + b)));
      end
    end
    res.overlapping = (cin < 0);
    return res;
  endfunction

  function void note_query(pair_query_t q);
    expected_q.push_back(predict(q));
  endfunction

  function void check_result(contact_times_t act);
    contact_times_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result with no pending query");
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (act.in_found !== exp_r.in_found) begin
      $error("in_found expected %0d actual %0d", exp_r.in_found, act.in_found);
      errors++;
    end
    if (act.in_time !== exp_r.in_time) begin
      $error("in_time expected %0h actual %0h", exp_r.in_time, act.in_time);
      errors++;
    end
    if (act.out_found !== exp_r.out_found) begin
      $error("out_found expected %0d actual %0d", exp_r.out_found, act.out_found);
      errors++;
    end
    if (act.out_time !== exp_r.out_time) begin
      $error("out_time expected %0h actual %0h", exp_r.out_time, act.out_time);
      errors++;
    end
    if (act.overlapping !== exp_r.overlapping) begin
      $error("overlapping expected %0d actual %0d", exp_r.overlapping,
             act.overlapping);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam longint Max47 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Unit  = 64'sd1 << 32;
  localparam int     CycleLimit = 400000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [gsct_pkg::WordW-1:0]        cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [gsct_pkg::WordW-1:0] rv_dot_i = '0;
  logic [gsct_pkg::TimeW-1:0]        vel_sq_i = '0;
  logic [gsct_pkg::TimeW-1:0]        dist_sq_i = '0;
  logic [gsct_pkg::TimeW-1:0]        diameter_sq_i = '0;
  logic [gsct_pkg::TimeW-1:0]        sys_time_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              in_found_o;
  logic [gsct_pkg::TimeW-1:0]        in_time_o;
  logic                              out_found_o;
  logic [gsct_pkg::TimeW-1:0]        out_time_o;
  logic                              overlapping_o;

  contact_scoreboard sb = new();
  int cycles = 0;
  int stall_pct = 0;
  int burst_left = 0;

  growing_sphere_collision_time u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the output at random, with a stall density of 0, 25, 50 or 75 percent that is redrawn periodically
  always @(negedge clk_i) begin
    if (cycles % 300 == 0) stall_pct = $urandom_range(0, 3) * 25;
    out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  // Note accepted queries and check delivered results
  always @(posedge clk_i) begin
    pair_query_t    q;
    contact_times_t r;
    cycles++;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      q.rv = longint'(rv_dot_i);
      q.v2 = longint'(vel_sq_i);
      q.r2 = longint'(dist_sq_i);
      q.d2 = longint'(diameter_sq_i);
      q.t = longint'(sys_time_i);
      sb.note_query(q);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.in_found = in_found_o;
      r.in_time = in_time_o;
      r.out_found = out_found_o;
      r.out_time = out_time_o;
      r.overlapping = overlapping_o;
      sb.check_result(r);
    end
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Write the growth rate once the pipe has drained
  task automatic write_growth(longint g);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (110) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = g[47:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.growth = g;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Send one query, with idle gaps between bursts
  task automatic send_query(longint rv, longint v2, longint r2, longint d2,
                            longint t);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i = 1'b1;
    rv_dot_i = rv[47:0];
    vel_sq_i = v2[46:0];
    dist_sq_i = r2[46:0];
    diameter_sq_i = d2[46:0];
    sys_time_i = t[46:0];
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic longint rand47();
    return {$urandom(), $urandom()} & Max47;
  endfunction

  // Value of moderate physical scale, below unity
  function automatic longint rand_scaled();
    return longint'($urandom()) >> $urandom_range(0, 16);
  endfunction

  task automatic random_queries(int n);
    longint rv;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        rv = rand47();
        if ($urandom_range(0, 1)) rv = -rv - 1;
        send_query(rv, rand47(), rand47(), rand47(), rand47());
      end else begin
        rv = rand_scaled();
        if ($urandom_range(0, 3) != 0) rv = -rv;
        send_query(rv, rand_scaled(), rand_scaled(), rand_scaled(),
                   rand_scaled() >> 2);
      end
    end
    in_valid_i = 1'b0;
    burst_left = 0;
  endtask

  initial begin
    longint rates[6];
    rates = '{Max47, -Max47 - 1, Unit >> 4, -(Unit >> 6), Unit * 3, 0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners at reset growth rate
    send_query(0, 0, 0, 0, 0);
    send_query(Max47, Max47, Max47, Max47, Max47);
    send_query(-Max47 - 1, Max47, 0, Max47, Max47);
    send_query(-Unit, Unit, 4 * Unit, Unit, 0);
    send_query(-Unit, Unit, Unit / 2, Unit, 0);
    send_query(Unit, Unit, Unit / 2, Unit, 0);
    send_query(-Unit, 0, 4 * Unit, Unit, 0);
    send_query(-1, 1, 1, 1, 1);
    send_query(-Max47 - 1, 0, Max47, 0, 0);
    in_valid_i = 1'b0;

    // Directed corners with growth, then random queries per rate
    write_growth(Unit >> 3);
    send_query(-Unit, Unit, 4 * Unit, Unit, 2 * Unit);
    send_query(0, Unit, Unit, Unit, 8 * Unit);
    send_query(-Max47 - 1, Max47, Max47, Max47, Max47);
    send_query(0, 0, 0, Max47, Max47);
    random_queries(250);
    foreach (rates[k]) begin
      write_growth(rates[k]);
      random_queries(k == 0 || k == 1 ? 100 : 260);
    end

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
